// ===== sv/hrkm_pkg.sv =====
`timescale 1ns / 1ps

package hrkm_pkg;

  // Key usage codes with special handling
  localparam logic [7:0] KeyRestore    = 8'h46;
  localparam logic [7:0] KeyShiftLock  = 8'h39;
  localparam logic [7:0] KeyResetCombo = 8'h4c;
  localparam logic [7:0] ModResetCombo = 8'h05;
  localparam logic [7:0] KeyCrsrRight  = 8'h4f;
  localparam logic [7:0] KeyCrsrLeft   = 8'h50;
  localparam logic [7:0] KeyCrsrDown   = 8'h51;
  localparam logic [7:0] KeyCrsrUp     = 8'h52;
  localparam logic [7:0] KeyF2         = 8'h3b;
  localparam logic [7:0] KeyF4         = 8'h3d;
  localparam logic [7:0] KeyF6         = 8'h3f;
  localparam logic [7:0] KeyF8         = 8'h41;
  localparam logic [7:0] KeyHotkeyLo   = 8'h42;
  localparam logic [7:0] KeyHotkeyHi   = 8'h45;

  // Modifier masks
  localparam logic [7:0] ModLShift     = 8'h02;
  localparam logic [7:0] ModRShift     = 8'h20;
  localparam logic [7:0] ModBothShift  = 8'h22;
  localparam logic [7:0] ModCtrl       = 8'h11;
  localparam logic [7:0] ModGui        = 8'h88;

  // Operation codes
  localparam logic OpReport = 1'b0;
  localparam logic OpRead   = 1'b1;

  // Matrix code table, index is {row, column}
  localparam logic [7:0] CodeGrid [64] = '{
    8'h2a, 8'h28, 8'h4f, 8'h40, 8'h3a, 8'h3c, 8'h3e, 8'h51,
    8'h20, 8'h1a, 8'h04, 8'h21, 8'h1d, 8'h16, 8'h08, 8'h00,
    8'h22, 8'h15, 8'h07, 8'h23, 8'h06, 8'h09, 8'h17, 8'h1b,
    8'h24, 8'h1c, 8'h0a, 8'h25, 8'h05, 8'h0b, 8'h18, 8'h19,
    8'h26, 8'h0c, 8'h0d, 8'h27, 8'h10, 8'h0e, 8'h12, 8'h11,
    8'h57, 8'h13, 8'h0f, 8'h56, 8'h37, 8'h33, 8'h2f, 8'h36,
    8'h49, 8'h55, 8'h34, 8'h4a, 8'h00, 8'h32, 8'h4b, 8'h54,
    8'h1e, 8'h4e, 8'h00, 8'h1f, 8'h2c, 8'h00, 8'h14, 8'h29
  };

  // Keys as seen by the matrix
  typedef struct packed {
    logic [7:0] mods;
    logic [7:0] first;
    logic [7:0] second;
  } held_t;

  // Full keyboard state
  typedef struct packed {
    held_t       held;
    logic [23:0] last_raw;
    logic        shift_lock;
  } kbd_state_t;

  // Side effects of one report
  typedef struct packed {
    logic       nmi;
    logic       rst_req;
    logic [2:0] hotkey;
  } report_flags_t;

endpackage

// ===== sv/hid_report_to_key_matrix.sv =====
`timescale 1ns / 1ps

// Keyboard matrix emulation fed from USB boot keyboard reports.
// Input channel (in_valid_i / in_stall_o) carries one word per operation:
//   operation 0 loads a report (modifiers, two key codes, text busy flag)
//   operation 1 reads the column byte for a row select and joystick bits.
// Output channel (out_valid_o / out_stall_i) returns one word per input:
//   the active-low column byte (0xff for reports) and the report flags
//   nmi_pulse, reset_request and hotkey_index (all zero for reads).
// Words pass through an input register, then the rules and matrix compare
// into the output register. Throughput is one word per clock while the
// receiver does not stall; the keyboard state updates when a word moves into
// the output register, so a read right after a report sees that report.
// When the receiver stalls, the output word holds and the input register
// keeps taking one more word; beyond that in_stall_o is raised.
// Reset clears held keys, last report, shift lock and both valid flags.
module hid_report_to_key_matrix (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       operation_i,
  input  logic [7:0] modifiers_i,
  input  logic [7:0] first_key_i,
  input  logic [7:0] second_key_i,
  input  logic       text_busy_i,
  input  logic [7:0] row_select_i,
  input  logic [7:0] joystick_bits_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] column_byte_o,
  output logic       nmi_pulse_o,
  output logic       reset_request_o,
  output logic [2:0] hotkey_index_o
);
  import hrkm_pkg::*;

  logic          in_vld_q;
  logic          op_q;
  logic [7:0]    mods_q, k1_q, k2_q, rsel_q, joy_q;
  logic          busy_q;
  logic          out_vld_q;
  logic [7:0]    col_q;
  report_flags_t flags_q;
  kbd_state_t    state_q, state_d;
  kbd_state_t    rpt_state;
  report_flags_t rpt_flags;
  logic [7:0]    col_rd;
  logic          advance;
  logic          accept;

  // Handshake: stage 1 moves on when the output register is free or taken
  assign advance    = !out_vld_q || !out_stall_i;
  assign in_stall_o = in_vld_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (advance || !in_vld_q) begin
      in_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= operation_i;
      mods_q <= modifiers_i;
      k1_q   <= first_key_i;
      k2_q   <= second_key_i;
      busy_q <= text_busy_i;
      rsel_q <= row_select_i;
      joy_q  <= joystick_bits_i;
    end
  end

  hrkm_report u_report (
    .state_i      (state_q),
    .modifiers_i  (mods_q),
    .first_key_i  (k1_q),
    .second_key_i (k2_q),
    .text_busy_i  (busy_q),
    .state_o      (rpt_state),
    .flags_o      (rpt_flags)
  );

  hrkm_column u_column (
    .held_i          (state_q.held),
    .row_select_i    (rsel_q),
    .joystick_bits_i (joy_q),
    .column_byte_o   (col_rd)
  );

  // Keyboard state update
  always_comb begin
    state_d = state_q;
    if (in_vld_q && advance && op_q == OpReport) begin
      state_d = rpt_state;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_vld_q) begin
      if (op_q == OpRead) begin
        col_q   <= col_rd;
        flags_q <= '0;
      end else begin
        col_q   <= 8'hff;
        flags_q <= rpt_flags;
      end
    end
  end

  assign out_valid_o     = out_vld_q;
  assign column_byte_o   = col_q;
  assign nmi_pulse_o     = flags_q.nmi;
  assign reset_request_o = flags_q.rst_req;
  assign hotkey_index_o  = flags_q.hotkey;

endmodule

// ===== sv/hrkm_report.sv =====
`timescale 1ns / 1ps

module hrkm_report (
  input  hrkm_pkg::kbd_state_t    state_i,
  input  logic [7:0]              modifiers_i,
  input  logic [7:0]              first_key_i,
  input  logic [7:0]              second_key_i,
  input  logic                    text_busy_i,
  output hrkm_pkg::kbd_state_t    state_o,
  output hrkm_pkg::report_flags_t flags_o
);
  import hrkm_pkg::*;

  logic [23:0] raw;
  logic        special;
  logic        go_on;

  assign raw     = {second_key_i, first_key_i, modifiers_i};
  assign special = (raw != state_i.last_raw) && (raw != '0) && !text_busy_i;

  // Report rules: hotkeys, reset combo, restore, shift lock, remaps
  always_comb begin
    state_o             = state_i;
    state_o.held.mods   = modifiers_i;
    state_o.held.first  = first_key_i;
    state_o.held.second = second_key_i;
    state_o.last_raw    = raw;
    flags_o             = '0;
    go_on               = 1'b0;
    if (special) begin
      if (first_key_i >= KeyHotkeyLo && first_key_i <= KeyHotkeyHi) begin
        flags_o.hotkey = 3'(KeyRestore - first_key_i);
      end else begin
        go_on = 1'b1;
        if (modifiers_i == ModResetCombo && first_key_i == KeyResetCombo) begin
          flags_o.rst_req = 1'b1;
        end else if (first_key_i == KeyRestore) begin
          state_o.held.first  = second_key_i;
          state_o.held.second = '0;
          flags_o.nmi         = 1'b1;
          go_on               = 1'b0;
        end else if (second_key_i == KeyRestore) begin
          state_o.held.second = '0;
          flags_o.nmi         = 1'b1;
          go_on               = 1'b0;
        end
      end
    end
    if (go_on) begin
      if (first_key_i == KeyShiftLock) begin
        state_o.held       = '0;
        state_o.shift_lock = ~state_i.shift_lock;
      end else begin
        if (state_i.shift_lock) begin
          state_o.held.mods = state_o.held.mods | ModLShift;
        end
        if (first_key_i == KeyCrsrRight || first_key_i == KeyCrsrDown) begin
          state_o.held.mods = state_o.held.mods & ~ModBothShift;
        end else if (first_key_i == KeyCrsrLeft) begin
          state_o.held.mods  = state_o.held.mods | ModRShift;
          state_o.held.first = KeyCrsrRight;
        end else if (first_key_i == KeyCrsrUp) begin
          state_o.held.mods  = state_o.held.mods | ModRShift;
          state_o.held.first = KeyCrsrDown;
        end else if (first_key_i == KeyF2 || first_key_i == KeyF4 ||
                     first_key_i == KeyF6 || first_key_i == KeyF8) begin
          state_o.held.mods  = state_o.held.mods | ModRShift;
          state_o.held.first = first_key_i - 8'd1;
        end
      end
    end
  end

endmodule

// ===== sv/hrkm_column.sv =====
`timescale 1ns / 1ps

module hrkm_column (
  input  hrkm_pkg::held_t held_i,
  input  logic [7:0]      row_select_i,
  input  logic [7:0]      joystick_bits_i,
  output logic [7:0]      column_byte_o
);
  import hrkm_pkg::*;

  logic [7:0] hits [8];
  logic [7:0] hit_or;
  logic [7:0] extra;
  logic [7:0] rows;

  assign rows = ~row_select_i;

  // Per-row key matches, all 64 cells compared in parallel
  always_comb begin
    for (int r = 0; r < 8; r++) begin
      hits[r] = '0;
      for (int c = 0; c < 8; c++) begin
        if (held_i.first != '0 &&
            (CodeGrid[{3'(r), 3'(c)}] == held_i.first ||
             (held_i.second != '0 && CodeGrid[{3'(r), 3'(c)}] == held_i.second))) begin
          hits[r][c] = 1'b1;
        end
      end
    end
  end

  // OR the selected rows together, plus modifier keys wired into the matrix
  always_comb begin
    hit_or = '0;
    extra  = '0;
    for (int r = 0; r < 8; r++) begin
      if (rows[r]) begin
        hit_or = hit_or | hits[r];
      end
    end
    if (rows[1] && (held_i.mods & ModLShift) != '0) begin
      extra[7] = 1'b1;
    end
    if (rows[6] && (held_i.mods & ModRShift) != '0) begin
      extra[4] = 1'b1;
    end
    if (rows[7] && (held_i.mods & ModCtrl) != '0) begin
      extra[2] = 1'b1;
    end
    if (rows[7] && (held_i.mods & ModGui) != '0) begin
      extra[5] = 1'b1;
    end
  end

  always_comb begin
    if (held_i == '0) begin
      column_byte_o = ~joystick_bits_i;
    end else if (row_select_i == '0) begin
      column_byte_o = '0;
    end else begin
      column_byte_o = ~(joystick_bits_i | hit_or | extra);
    end
  end

endmodule

// ===== sv/hrkm_checker.sv =====
`timescale 1ns / 1ps

module hrkm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] column_byte_o,
  input logic       nmi_pulse_o,
  input logic       reset_request_o,
  input logic [2:0] hotkey_index_o
);

  // Stalled output word stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // Stalled output word keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(column_byte_o) && $stable(nmi_pulse_o)
      && $stable(reset_request_o) && $stable(hotkey_index_o))
    else $error("output word changed while stalled");

  // Restore and reset combo are exclusive
  a_flag_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(nmi_pulse_o && reset_request_o))
    else $error("nmi and reset request in one word");

  // Hotkey word carries no other flag and a released column byte
  a_hotkey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hotkey_index_o != 3'd0 |->
      !nmi_pulse_o && !reset_request_o && column_byte_o == 8'hff &&
      hotkey_index_o <= 3'd4)
    else $error("bad hotkey word");

  // Report flags only come from reports
  a_flag_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (nmi_pulse_o || reset_request_o) |-> column_byte_o == 8'hff)
    else $error("report flag on a column read");

endmodule

bind hid_report_to_key_matrix hrkm_checker u_hrkm_checker (.*);
